// ===== design/vadpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// VADPCM decoder package
// Shared widths, command codes and helper functions.
// ----------------------------------------------------------------------------
package vadpcm_pkg;

    localparam int MAX_PREDICTORS_DEF = 16;
    localparam int BOOK_DEPTH         = 256;
    localparam int BOOK_AW            = 8;
    localparam int SAMPLE_W           = 16;
    localparam int ACC_W              = 40;
    localparam int FRAME_BYTES        = 9;
    localparam int GROUP_SAMPLES      = 8;
    localparam int FRAME_SAMPLES      = 16;
    localparam int PRED_CNT_W         = 5;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [3:0] SCALE_CAP = 4'd12;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [7:0]  coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               status;
    } t_out_item;

    // Residual: sign-extended nibble shifted left by the capped scale.
    function automatic logic signed [19:0] make_residual(input logic [3:0] nib,
                                                         input logic [3:0] scale);
        logic [3:0]         sh;
        logic signed [19:0] sn;
        sh = (scale < SCALE_CAP) ? scale : SCALE_CAP;
        sn = 20'(signed'(nib));
        return sn <<< sh;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-12:0] q;
        q = acc[ACC_W-1:11];
        if (q > 32767) begin
            return 16'sh7fff;
        end else if (q < -32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

endpackage

// ===== design/vadpcm_if.sv =====
// ----------------------------------------------------------------------------
// VADPCM channel interfaces
// Valid/ready channels for the input requests and the decoded samples.
// ----------------------------------------------------------------------------
interface vadpcm_in_if;
    logic                  valid;
    logic                  ready;
    vadpcm_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vadpcm_out_if;
    logic                  valid;
    logic                  ready;
    vadpcm_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/vadpcm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vadpcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/vadpcm_mac.sv =====
// ----------------------------------------------------------------------------
// VADPCM multiply-accumulate unit
// Registered 16x20 product added into a 40-bit accumulator.
// ----------------------------------------------------------------------------
module vadpcm_mac (
    input  logic                     i_clk,
    input  logic                     i_clr,
    input  logic                     i_en,
    input  logic signed [15:0]       i_a,
    input  logic signed [19:0]       i_b,
    output logic signed [vadpcm_pkg::ACC_W-1:0] o_acc
);
    import vadpcm_pkg::*;

    logic signed [35:0]      r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        r_prod     <= i_a * i_b;
        r_prod_vld <= i_en;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== design/adpcm_order2_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// Order-2 VADPCM frame decoder
// Decodes 9-byte frames into 16 PCM samples with a shared MAC.
// ----------------------------------------------------------------------------
// The last byte of a frame starts the decode. Sample s of each group of eight
// needs s + 3 products into one MAC, the residual by 2048 and the rest by
// codebook RAM entries (one read a cycle). The products then drain through
// ST_WAIT into the accumulator, and ST_OUT loads the result register. No
// request is taken during the decode or while a sample waits in the result
// register.
module adpcm_order2_frame_decoder #(
    parameter int MAX_PREDICTORS = vadpcm_pkg::MAX_PREDICTORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vadpcm_pkg::PRED_CNT_W-1:0]   i_cfg_wdata,
    vadpcm_in_if.sink                           in_ch,
    vadpcm_out_if.source                        out_ch
);
    import vadpcm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TERM = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    localparam logic [PRED_CNT_W-1:0] MAXP = PRED_CNT_W'(MAX_PREDICTORS);

    logic [2:0]              r_state;
    logic [PRED_CNT_W-1:0]   r_pcount;
    logic [3:0]              r_pos;
    logic                    r_lock;
    logic [7:0]              r_header;
    logic [7:0]              r_nib [8];
    logic signed [15:0]      r_hist [FRAME_SAMPLES];
    logic signed [15:0]      r_older, r_newer;
    logic [3:0]              r_samp;
    logic [3:0]              r_term;
    logic [3:0]              r_wait;
    logic                    r_ovld;
    t_out_item               r_out;

    logic                    w_take;
    logic [PRED_CNT_W-1:0]   w_limit;
    logic [BOOK_AW-1:0]      w_raddr;
    logic [15:0]             w_rdata;
    logic                    r_rd_vld;
    logic signed [19:0]      r_mult;
    logic signed [19:0]      w_mult;
    logic signed [15:0]      w_coef;
    logic                    w_mac_en;
    logic                    w_mac_clr;
    logic signed [ACC_W-1:0] w_acc;
    logic [2:0]              w_s;
    logic [3:0]              w_nterms;
    logic signed [15:0]      w_sat;

    assign w_limit = (r_pcount < MAXP) ? r_pcount : MAXP;
    assign w_take  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == ST_IDLE) && !r_ovld;

    assign w_s    = r_samp[2:0];
    // Terms: 0 residual, 1 older, 2 newer, 3.. earlier residuals.
    assign w_nterms = 4'(w_s) + 4'd3;

    function automatic logic signed [19:0] resid(input logic [3:0] k,
                                                 input logic [7:0] hdr,
                                                 input logic [7:0] b);
        return make_residual(k[0] ? b[3:0] : b[7:4], hdr[7:4]);
    endfunction

    always_comb begin
        logic [3:0] k;
        logic [3:0] cidx;
        k      = r_samp;
        cidx   = 4'(w_s);
        w_mult = '0;
        case (r_term)
            4'd0: begin
                cidx   = 4'd0;
                w_mult = resid(r_samp, r_header, r_nib[r_samp[3:1]]);
            end
            4'd1: begin
                cidx   = 4'(w_s);
                w_mult = 20'(r_samp[3] ? r_hist[6] : r_older);
            end
            4'd2: begin
                cidx   = 4'(w_s) + 4'd8;
                w_mult = 20'(r_samp[3] ? r_hist[7] : r_newer);
            end
            default: begin
                cidx   = 4'd8 + (r_term - 4'd3);
                k      = r_samp - 4'd1 - (r_term - 4'd3);
                w_mult = resid(k, r_header, r_nib[k[3:1]]);
            end
        endcase
        w_raddr = {r_header[3:0], cidx};
    end

    vadpcm_ram #(.WIDTH(16), .DEPTH(BOOK_DEPTH)) u_book (
        .i_clk   (i_clk),
        .i_we    (w_take && in_ch.payload.cmd == CMD_LOAD),
        .i_waddr (in_ch.payload.coef_index),
        .i_wdata (in_ch.payload.coef_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The residual term multiplies 2048, not a codebook entry.
    logic r_first;
    assign w_coef    = r_first ? 16'sd2048 : signed'(w_rdata);
    assign w_mac_en  = r_rd_vld;
    assign w_mac_clr = (r_state == ST_IDLE) || (r_state == ST_OUT && !r_ovld);

    vadpcm_mac u_mac (
        .i_clk (i_clk),
        .i_clr (w_mac_clr),
        .i_en  (w_mac_en),
        .i_a   (w_coef),
        .i_b   (r_mult),
        .o_acc (w_acc)
    );

    assign w_sat = sat16(w_acc);

    always_ff @(posedge i_clk) begin
        r_mult   <= w_mult;
        r_first  <= (r_state == ST_TERM) && (r_term == 4'd0);
        if (w_take && in_ch.payload.cmd == CMD_BYTE && !r_lock) begin
            if (r_pos == 4'd0) begin
                r_header <= in_ch.payload.data_byte;
            end else begin
                r_nib[3'(r_pos - 4'd1)] <= in_ch.payload.data_byte;
            end
        end
        if (r_state == ST_OUT && !r_ovld) begin
            r_hist[r_samp] <= w_sat;
            r_out.sample   <= w_sat;
            r_out.last     <= (r_samp == 4'(FRAME_SAMPLES - 1));
            r_out.status   <= 1'b0;
        end else if (r_state == ST_ERR) begin
            r_out.sample <= '0;
            r_out.last   <= 1'b1;
            r_out.status <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pcount <= PRED_CNT_W'(1);
            r_pos    <= '0;
            r_lock   <= 1'b0;
            r_older  <= '0;
            r_newer  <= '0;
            r_samp   <= '0;
            r_term   <= '0;
            r_wait   <= '0;
            r_ovld   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_TERM);
            if (i_cfg_we) begin
                r_pcount <= i_cfg_wdata;
            end
            if (r_ovld && out_ch.ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        case (in_ch.payload.cmd)
                            CMD_START: begin
                                r_older <= '0;
                                r_newer <= '0;
                                r_pos   <= '0;
                                r_lock  <= 1'b0;
                            end
                            CMD_BYTE: begin
                                if (!r_lock) begin
                                    if (r_pos == 4'd0) begin
                                        if ({1'b0, in_ch.payload.data_byte[3:0]} >=
                                            w_limit) begin
                                            r_lock  <= 1'b1;
                                            r_state <= ST_ERR;
                                        end else begin
                                            r_pos <= 4'd1;
                                        end
                                    end else if (r_pos < 4'(FRAME_BYTES - 1)) begin
                                        r_pos <= r_pos + 4'd1;
                                    end else begin
                                        r_pos   <= '0;
                                        r_samp  <= '0;
                                        r_term  <= '0;
                                        r_state <= ST_TERM;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TERM: begin
                    if (r_term == w_nterms - 4'd1) begin
                        r_term  <= '0;
                        r_wait  <= '0;
                        r_state <= ST_WAIT;
                    end else begin
                        r_term <= r_term + 4'd1;
                    end
                end
                ST_WAIT: begin
                    // RAM read and product register drain into the accumulator.
                    r_wait <= r_wait + 4'd1;
                    if (r_wait == 4'd2) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovld) begin
                        r_ovld <= 1'b1;
                        if (r_samp == 4'(FRAME_SAMPLES - 1)) begin
                            r_older <= r_hist[14];
                            r_newer <= w_sat;
                            r_state <= ST_IDLE;
                        end else begin
                            r_samp  <= r_samp + 4'd1;
                            r_state <= ST_TERM;
                        end
                    end
                end
                ST_ERR: begin
                    r_ovld  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid   = r_ovld;
    assign out_ch.payload = r_out;

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready)
        else $error("request taken during decode");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_ovld) |=> (r_state == ST_OUT || r_state == ST_IDLE))
        else $error("decode advanced with pending sample");
    a_err_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERR) |-> r_lock)
        else $error("error result without lock");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 4'(FRAME_BYTES))
        else $error("byte position out of range");
`endif
endmodule

// ===== tb/adpcm_order2_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// Order-2 VADPCM frame decoder testbench
// Loads a codebook, then feeds directed and random request streams (frames,
// starts, coefficient loads, stray bytes) under several idle and stall
// profiles and predictor counts, checking every decoded sample against an
// in-bench decoder.
// ----------------------------------------------------------------------------
module adpcm_order2_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vadpcm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BAD_PRED = 1'b1;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 28;
    localparam int BOOK_PREDS = 4;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [PRED_CNT_W-1:0] cfg_wdata;

    vadpcm_in_if  in_ch();
    vadpcm_out_if out_ch();

    adpcm_order2_frame_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    shortint   codebook [256];
    shortint   hist_old;
    shortint   hist_new;
    logic [7:0] hdr_byte;
    logic [7:0] nib_bytes [8];
    int        frame_pos;
    bit        pred_locked;
    int        pred_count;
    t_out_item new_samples [$];
    t_out_item expected_samples [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatches;
    t_row      directed [$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic shortint clip16(input longint acc);
        longint q;
        q = acc >>> 11;
        if (q > 32767) begin
            return 16'sh7fff;
        end
        if (q < -32768) begin
            return 16'sh8000;
        end
        return shortint'(q);
    endfunction

    function automatic void decode_frame();
        int        resid [16];
        shortint   pcm [16];
        int        base;
        int        shift;
        int        nib;
        longint    acc;
        longint    prev_a;
        longint    prev_b;
        t_out_item o;
        base = int'(hdr_byte[3:0]) * 16;
        shift = (hdr_byte[7:4] < 12) ? int'(hdr_byte[7:4]) : 12;
        for (int k = 0; k < 16; k++) begin
            nib = (k % 2) ? nib_bytes[k / 2][3:0] : nib_bytes[k / 2][7:4];
            if (nib >= 8) begin
                nib -= 16;
            end
            resid[k] = nib * (1 << shift);
        end
        for (int g = 0; g < 2; g++) begin
            prev_a = (g == 0) ? longint'(hist_old) : longint'(pcm[6]);
            prev_b = (g == 0) ? longint'(hist_new) : longint'(pcm[7]);
            for (int s = 0; s < 8; s++) begin
                acc = longint'(resid[g * 8 + s]) * 2048;
                acc += longint'(codebook[base + s]) * prev_a;
                acc += longint'(codebook[base + 8 + s]) * prev_b;
                for (int p = 0; p < s; p++) begin
                    acc += longint'(codebook[base + 8 + p]) * longint'(resid[g * 8 + s - 1 - p]);
                end
                pcm[g * 8 + s] = clip16(acc);
            end
        end
        hist_old = pcm[14];
        hist_new = pcm[15];
        for (int k = 0; k < 16; k++) begin
            o.sample = pcm[k];
            o.last = (k == 15);
            o.status = STATUS_OK;
            new_samples.push_back(o);
        end
    endfunction

    function automatic void apply_request(input t_in_item it);
        int        limit;
        t_out_item o;
        case (it.cmd)
            CMD_LOAD: begin
                codebook[it.coef_index] = it.coef_value;
            end
            CMD_START: begin
                hist_old = 0;
                hist_new = 0;
                frame_pos = 0;
                pred_locked = 1'b0;
            end
            CMD_BYTE: begin
                if (!pred_locked) begin
                    if (frame_pos == 0) begin
                        limit = (pred_count < MAX_PREDICTORS_DEF) ? pred_count
                                                                   : MAX_PREDICTORS_DEF;
                        hdr_byte = it.data_byte;
                        if (int'(it.data_byte[3:0]) >= limit) begin
                            pred_locked = 1'b1;
                            o.sample = 0;
                            o.last = 1'b1;
                            o.status = STATUS_BAD_PRED;
                            new_samples.push_back(o);
                        end else begin
                            frame_pos = 1;
                        end
                    end else begin
                        nib_bytes[frame_pos - 1] = it.data_byte;
                        if (frame_pos < FRAME_BYTES - 1) begin
                            frame_pos++;
                        end else begin
                            frame_pos = 0;
                            decode_frame();
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Either a predictor whose codebook rows were loaded, or one out of range.
    function automatic int pick_pred(input int limit);
        int usable;
        usable = (limit < BOOK_PREDS) ? limit : BOOK_PREDS;
        if (usable > 0 && (limit >= 16 || $urandom_range(99) < 85)) begin
            return $urandom_range(usable - 1);
        end
        return limit + $urandom_range(15 - limit);
    endfunction

    function automatic t_in_item mk_req(input logic [1:0] cmd, input logic [7:0] data,
                                        input logic [7:0] idx, input int val);
        t_in_item it;
        it.cmd = cmd;
        it.data_byte = data;
        it.coef_index = idx;
        it.coef_value = 16'(val);
        return it;
    endfunction

    task automatic send_request(input t_in_item it, input bit typed, input t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        new_samples.delete();
        apply_request(it);
        if (typed) begin
            expected_samples.push_back(want);
        end else begin
            foreach (new_samples[k]) begin
                expected_samples.push_back(new_samples[k]);
            end
        end
    endtask

    task automatic send(input t_in_item it);
        t_out_item none;
        none = '0;
        send_request(it, 1'b0, none);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pred_count(input int v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= PRED_CNT_W'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pred_count = v;
    endtask

    task automatic random_phase(input int n_items);
        int r;
        int limit;
        int pred;
        int val;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            limit = (pred_count < 16) ? pred_count : 16;
            if (pred_locked && r < 80) begin
                send(mk_req(CMD_START, 8'($urandom), 8'($urandom), $urandom));
                sent++;
            end else if (r < 5) begin
                send(mk_req(CMD_START, 8'($urandom), 8'($urandom), $urandom));
                sent++;
            end else if (r < 11) begin
                val = ($urandom_range(4) == 0) ? int'($urandom) : $urandom_range(6000) - 3000;
                send(mk_req(CMD_LOAD, 8'($urandom), 8'($urandom), val));
                sent++;
            end else if (r < 14) begin
                send(mk_req(CMD_UNUSED, 8'($urandom), 8'($urandom), $urandom));
                sent++;
            end else if (r < 18) begin
                send(mk_req(CMD_BYTE, {4'($urandom), 4'(pick_pred(limit))}, 8'($urandom),
                            $urandom));
                sent++;
            end else begin
                pred = pick_pred(limit);
                send(mk_req(CMD_BYTE, {4'($urandom), 4'(pred)}, 8'($urandom), $urandom));
                for (int k = 0; k < 8; k++) begin
                    send(mk_req(CMD_BYTE, 8'($urandom), 8'($urandom), $urandom));
                end
                sent += 9;
            end
        end
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_samples.size() == 0) begin
                $error("sample with none expected: %0d", out_ch.payload.sample);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (out_ch.payload.sample !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, out_ch.payload.sample);
                    mismatches++;
                end
                if (out_ch.payload.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_ch.payload.last);
                    mismatches++;
                end
                if (out_ch.payload.status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, out_ch.payload.status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("adpcm_order2_frame_decoder_tb failed");
        $finish;
    end

    initial begin
        t_out_item err_sample;
        int        counts [5];
        int        idle_sets [4][2];
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hist_old = 0;
        hist_new = 0;
        frame_pos = 0;
        pred_locked = 1'b0;
        pred_count = 1;
        hdr_byte = '0;
        foreach (codebook[k]) begin
            codebook[k] = 0;
        end
        foreach (nib_bytes[k]) begin
            nib_bytes[k] = '0;
        end
        err_sample.sample = 0;
        err_sample.last = 1'b1;
        err_sample.status = STATUS_BAD_PRED;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < BOOK_PREDS * 16; k++) begin
            send(mk_req(CMD_LOAD, 8'h00, 8'(k), $urandom_range(8000) - 4000));
        end

        directed.push_back('{mk_req(CMD_LOAD, 8'h00, 8'h00, -32768), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_LOAD, 8'h00, 8'hff, 32767), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_START, 8'h00, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h01, 8'h00, 0), 1'b1, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'hff, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_UNUSED, 8'hff, 8'hff, -1), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_START, 8'h00, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'hf0, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h88, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h7f, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'hf7, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h08, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h80, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h00, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'hff, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'h77, 8'h00, 0), 1'b0, err_sample});
        directed.push_back('{mk_req(CMD_BYTE, 8'hc0, 8'h00, 0), 1'b0, err_sample});
        for (int k = 0; k < 8; k++) begin
            directed.push_back('{mk_req(CMD_BYTE, (k % 2) ? 8'h77 : 8'h88, 8'h00, 0),
                                 1'b0, err_sample});
        end
        foreach (directed[k]) begin
            send_request(directed[k].req, directed[k].typed, directed[k].want);
        end

        counts = '{16, 0, 31, 17, 1 + $urandom_range(15)};
        idle_sets = '{'{0, 0}, '{77, 0}, '{0, 77}, '{14, 14}};
        for (int ph = 0; ph < 5; ph++) begin
            set_pred_count(counts[ph]);
            send(mk_req(CMD_START, 8'h00, 8'h00, 0));
            for (int q = 0; q < 4; q++) begin
                send_idle_pct = idle_sets[(ph + q) % 4][0];
                recv_stall_pct = idle_sets[(ph + q) % 4][1];
                random_phase(RANDOM_ITEMS / 4);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        if (mismatches == 0) begin
            $display("adpcm_order2_frame_decoder_tb passed");
        end else begin
            $display("adpcm_order2_frame_decoder_tb failed");
        end
        $finish;
    end

endmodule
